FILE: hdl/mpd_pkg.sv
// shared types and constants for the monitor packet deframer
package mpd_pkg;

  // default number of ecg payload bytes per packet
  localparam int unsigned EcgPayloadBytesDef = 7;

  // payload store depth and index width
  localparam int unsigned PayloadSlots = 7;
  localparam int unsigned SlotIdxW     = 3;

  // packet id bytes
  localparam logic [7:0] IdEcg  = 8'h08;
  localparam logic [7:0] IdSpo2 = 8'h09;
  localparam logic [7:0] IdIbp  = 8'h0a;

  // packet kind codes on the result channel
  localparam logic [1:0] KindEcg  = 2'd0;
  localparam logic [1:0] KindSpo2 = 2'd1;
  localparam logic [1:0] KindIbp  = 2'd2;

  // one decoded packet
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] first;
    logic [15:0] second;
    logic [15:0] third;
  } mpd_result_t;

endpackage

FILE: hdl/monitor_packet_deframer_top.sv
// top level of the monitor packet deframer
//
// Reassembles packets from a patient monitor serial stream, one byte a beat.
// Input channel: rx_byte_i with in_valid_i / in_stall_o. A byte below 0x80
// restarts the search and is taken as a packet id (0x08 ecg, 0x09 spo2,
// 0x0a ibp); the next byte is an msb header, then the payload bytes, then a
// checksum byte that is not checked.
// Output channel: packet_kind_o and value_first_o..value_third_o with
// out_valid_o / out_stall_i. One beat is produced per packet, on its checksum.
// Throughput: one byte per cycle while in_stall_o stays low. The path is an
// input register followed by the decode logic that loads the result register,
// so the checksum byte is held in the input register before its result is loaded.
// When the receiver stalls, the result register holds; the decode stage then
// waits and the input register holds one more byte, after which in_stall_o
// rises until the receiver takes the result.
// Reset clears the packet phase, the slot index and the header; the result
// and input registers come up empty.
module monitor_packet_deframer_top
  import mpd_pkg::*;
#(
  parameter int unsigned ECG_PAYLOAD_BYTES = EcgPayloadBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  packet_kind_o,
  output logic [15:0] value_first_o,
  output logic [15:0] value_second_o,
  output logic [15:0] value_third_o
);

  logic        advance;
  logic        step;
  logic [7:0]  byte_q;
  logic        res_valid;
  mpd_result_t res_d;
  mpd_result_t res_q;

  // input register
  mpd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .in_stall_o (in_stall_o),
    .step_o     (step),
    .byte_o     (byte_q)
  );

  // decode logic and packet state
  mpd_core #(
    .ECG_PAYLOAD_BYTES (ECG_PAYLOAD_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  // result register
  mpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res_d),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .advance_o   (advance),
    .res_o       (res_q)
  );

  // result fields
  assign packet_kind_o  = res_q.kind;
  assign value_first_o  = res_q.first;
  assign value_second_o = res_q.second;
  assign value_third_o  = res_q.third;

endmodule

FILE: hdl/mpd_in_reg.sv
// input register stage for received bytes
module mpd_in_reg
  import mpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       in_stall_o,
  output logic       step_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // hold the beat while the decode stage cannot move
  assign in_stall_o = valid_q && !advance_i;
  assign step_o     = valid_q && advance_i;
  assign byte_o     = byte_q;

  // control bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // byte payload
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

FILE: hdl/mpd_core.sv
// packet phase tracking, msb restore and payload store
module mpd_core
  import mpd_pkg::*;
#(
  parameter int unsigned ECG_PAYLOAD_BYTES = EcgPayloadBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output logic        res_valid_o,
  output mpd_result_t res_o
);

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhEcgHdr  = 4'd1,
    PhEcgData = 4'd2,
    PhEcgSum  = 4'd3,
    PhSpoHdr  = 4'd4,
    PhSpoData = 4'd5,
    PhSpoSum  = 4'd6,
    PhIbpHdr  = 4'd7,
    PhIbpData = 4'd8,
    PhIbpSum  = 4'd9
  } phase_e;

  localparam logic [SlotIdxW-1:0] EcgLast  = SlotIdxW'(ECG_PAYLOAD_BYTES);
  localparam logic [SlotIdxW-1:0] SlotNone = SlotIdxW'(PayloadSlots);

  phase_e              phase_q, phase_d, phase_eff;
  logic [SlotIdxW-1:0] idx_q, idx_d, idx_inc;
  logic [7:0]          hdr_q, hdr_d;
  logic [7:0]          payload_q [PayloadSlots];
  logic                wr_en;
  logic [SlotIdxW-1:0] wr_idx;
  logic [7:0]          wr_data;

  // a low byte always restarts the packet search
  assign phase_eff = byte_i[7] ? phase_q : PhIdle;
  assign idx_inc   = idx_q + 1'b1;

  // next state, payload write and result
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    hdr_d       = hdr_q;
    wr_en       = 1'b0;
    wr_idx      = '0;
    wr_data     = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_eff)
      PhEcgHdr: begin
        hdr_d   = byte_i;
        phase_d = PhEcgData;
      end
      PhSpoHdr: begin
        hdr_d   = byte_i;
        phase_d = PhSpoData;
      end
      PhIbpHdr: begin
        hdr_d   = byte_i;
        phase_d = PhIbpData;
      end
      PhEcgData: begin
        wr_en   = (idx_q != SlotNone);
        wr_idx  = idx_q;
        wr_data = {hdr_q[idx_q], byte_i[6:0]};
        idx_d   = idx_inc;
        if (idx_inc == '0 || idx_inc >= EcgLast) begin
          phase_d = PhEcgSum;
        end
      end
      PhSpoData, PhIbpData: begin
        wr_en   = 1'b1;
        wr_idx  = '0;
        wr_data = {hdr_q[0], byte_i[6:0]};
        idx_d   = SlotIdxW'(1);
        phase_d = (phase_eff == PhSpoData) ? PhSpoSum : PhIbpSum;
      end
      PhEcgSum: begin
        res_valid_o  = 1'b1;
        res_o.kind   = KindEcg;
        res_o.first  = {payload_q[0], payload_q[1]};
        res_o.second = {payload_q[2], payload_q[3]};
        res_o.third  = {payload_q[4], payload_q[5]};
        phase_d      = PhIdle;
      end
      PhSpoSum, PhIbpSum: begin
        res_valid_o = 1'b1;
        res_o.kind  = (phase_eff == PhSpoSum) ? KindSpo2 : KindIbp;
        res_o.first = {8'h00, payload_q[0]};
        phase_d     = PhIdle;
      end
      default: begin
        // idle and unused codes: look for a packet id
        phase_d = PhIdle;
        if (byte_i == IdEcg) begin
          phase_d = PhEcgHdr;
          idx_d   = '0;
        end else if (byte_i == IdSpo2) begin
          phase_d = PhSpoHdr;
          idx_d   = '0;
        end else if (byte_i == IdIbp) begin
          phase_d = PhIbpHdr;
          idx_d   = '0;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      idx_q   <= '0;
      hdr_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      hdr_q   <= hdr_d;
    end
  end

  // restored payload bytes
  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      payload_q[wr_idx] <= wr_data;
    end
  end

endmodule

FILE: hdl/mpd_out_reg.sv
// result register toward the receiver
module mpd_out_reg
  import mpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        res_valid_i,
  input  mpd_result_t res_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic        advance_o,
  output mpd_result_t res_o
);

  logic        valid_q;
  mpd_result_t res_q;

  // the decode stage may move when this register is free or being drained
  assign advance_o   = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (step_i) begin
      valid_q <= res_valid_i;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    if (step_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: test/monitor_packet_deframer_top_tb.sv
// self-checking testbench for the monitor packet deframer top level
`timescale 1ns / 100ps

module monitor_packet_deframer_top_tb;
  import mpd_pkg::*;

  localparam int unsigned EcgBytes   = EcgPayloadBytesDef;
  localparam int unsigned RandBytes  = 1050;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned HoldAfter  = 350;
  localparam int unsigned DrainWait  = 20;

  // packet phases of the predictor
  typedef enum logic [3:0] {
    PhIdle = 4'd0,
    PhEcgHdr, PhEcgData, PhEcgSum,
    PhSpoHdr, PhSpoData, PhSpoSum,
    PhIbpHdr, PhIbpData, PhIbpSum
  } deframe_phase_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic [7:0]  rx_byte     = 8'h00;
  logic        out_stall   = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  packet_kind;
  logic [15:0] value_first;
  logic [15:0] value_second;
  logic [15:0] value_third;

  // predictor state
  deframe_phase_e ph       = PhIdle;
  logic [2:0]     slot_idx = '0;
  logic [7:0]     hdr      = '0;
  logic [7:0]     slots [PayloadSlots];

  logic [7:0]  byte_queue [$];
  mpd_result_t expected_packets [$];

  int unsigned accepted_bytes = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 1;
  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned mode_left      = 0;
  int unsigned stall_pct      = 0;

  monitor_packet_deframer_top #(
    .ECG_PAYLOAD_BYTES(EcgBytes)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .packet_kind_o  (packet_kind),
    .value_first_o  (value_first),
    .value_second_o (value_second),
    .value_third_o  (value_third)
  );

  // clock and reset
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // advance the deframer model by one accepted byte
  task automatic deframe_byte(input logic [7:0] b);
    logic [2:0]  idx;
    mpd_result_t res;
    idx = slot_idx;
    if (b < 8'h80) ph = PhIdle;
    case (ph)
      PhEcgHdr, PhSpoHdr, PhIbpHdr: begin
        hdr = b;
        ph  = deframe_phase_e'(ph + 4'd1);
      end
      PhEcgData: begin
        if (idx < PayloadSlots) slots[idx] = {hdr[idx], b[6:0]};
        idx      = idx + 3'd1;
        slot_idx = idx;
        if (idx == 3'd0 || idx >= EcgBytes) ph = PhEcgSum;
      end
      PhSpoData, PhIbpData: begin
        slots[0] = {hdr[0], b[6:0]};
        slot_idx = 3'd1;
        ph       = deframe_phase_e'(ph + 4'd1);
      end
      PhEcgSum: begin
        res.kind   = KindEcg;
        res.first  = {slots[0], slots[1]};
        res.second = {slots[2], slots[3]};
        res.third  = {slots[4], slots[5]};
        expected_packets.push_back(res);
        ph = PhIdle;
      end
      PhSpoSum, PhIbpSum: begin
        res.kind   = (ph == PhSpoSum) ? KindSpo2 : KindIbp;
        res.first  = {8'h00, slots[0]};
        res.second = '0;
        res.third  = '0;
        expected_packets.push_back(res);
        ph = PhIdle;
      end
      default: begin
        // idle and unused codes: look for a packet id
        ph = PhIdle;
        if (b == IdEcg) begin
          ph = PhEcgHdr;
          slot_idx = '0;
        end else if (b == IdSpo2) begin
          ph = PhSpoHdr;
          slot_idx = '0;
        end else if (b == IdIbp) begin
          ph = PhIbpHdr;
          slot_idx = '0;
        end
      end
    endcase
  endtask

  // queue one packet, cut short by a low byte at position cut when cut is not negative
  task automatic queue_packet(input logic [7:0] id, input int cut);
    int total;
    total = 3 + ((id == IdEcg) ? EcgBytes : 1);
    for (int i = 0; i < total; i++) begin
      if (i == cut) begin
        byte_queue.push_back(8'($urandom_range(0, 8'h7f)));
        return;
      end
      if (i == 0) byte_queue.push_back(id);
      else byte_queue.push_back(8'h80 | 8'($urandom_range(0, 8'h7f)));
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // stimulus and end of run
  initial begin
    logic [7:0] id;
    int unsigned pick;
    for (int i = 0; i < PayloadSlots; i++) slots[i] = '0;

    // high bytes while idle and unknown ids
    byte_queue.push_back(8'hff);
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'h7f);
    byte_queue.push_back(8'h0b);
    // ecg with every restored bit set
    byte_queue.push_back(IdEcg);
    repeat (EcgBytes + 2) byte_queue.push_back(8'hff);
    // spo2 with a cleared restored msb
    byte_queue.push_back(IdSpo2);
    byte_queue.push_back(8'h80);
    byte_queue.push_back(8'h80);
    byte_queue.push_back(8'hff);
    // ibp whose checksum is low and restarts as a new ibp id
    byte_queue.push_back(IdIbp);
    byte_queue.push_back(8'h81);
    byte_queue.push_back(8'hff);
    byte_queue.push_back(IdIbp);
    byte_queue.push_back(8'hfe);
    byte_queue.push_back(8'haa);
    byte_queue.push_back(8'h80);

    // random mix: mostly whole packets, some broken ones and line noise
    while (byte_queue.size() < RandBytes + 25) begin
      pick = $urandom_range(0, 2);
      id = (pick == 0) ? IdEcg : (pick == 1) ? IdSpo2 : IdIbp;
      pick = $urandom_range(0, 99);
      if (pick < 75) queue_packet(id, -1);
      else if (pick < 87) queue_packet(id, $urandom_range(1, 3 + EcgBytes));
      else repeat ($urandom_range(1, 4)) byte_queue.push_back(8'($urandom_range(0, 255)));
    end

    // wait for every beat to go in and every packet to come out
    do @(negedge clk_i); while (byte_queue.size() != 0 || in_valid);
    do @(negedge clk_i); while (expected_packets.size() != 0);
    repeat (DrainWait) @(negedge clk_i);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // sender: bursts of beats with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      rx_byte    <= 8'h00;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(rx_byte);
        accepted_bytes <= accepted_bytes + 1;
      end
      // free to present the next beat
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          rx_byte  <= byte_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_bytes >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = LongHold;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 90;
        endcase
      end
      mode_left = mode_left - 1;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    mpd_result_t exp_r;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_packets.size() == 0) begin
        $display("%0t unexpected result: expected none actual kind %0d %h %h %h", $time,
                 packet_kind, value_first, value_second, value_third);
        mismatch_count++;
      end else begin
        exp_r = expected_packets.pop_front();
        compare_field("packet_kind", {14'd0, exp_r.kind}, {14'd0, packet_kind});
        compare_field("value_first", exp_r.first, value_first);
        compare_field("value_second", exp_r.second, value_second);
        compare_field("value_third", exp_r.third, value_third);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("status: fail");
      $finish;
    end
  end

endmodule
